[rtl/core/ilst_pkg.sv]
package ilst_pkg;

   // Fixed field widths of the channel payloads
   localparam int ACTION_BITS       = 3;
   localparam int INDEX_BITS        = 7;
   localparam int SECOND_INDEX_BITS = 6;
   localparam int DATA_BITS         = 32;
   localparam int STATUS_BITS       = 2;
   localparam int COUNT_BITS        = 7;

   // Defaults for the top-level parameters
   localparam int CAPACITY_DEF   = 64;
   localparam int VALUE_BITS_DEF = 32;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_INSERT  = 3'd0,
      ACT_REMOVE  = 3'd1,
      ACT_REPLACE = 3'd2,
      ACT_READ    = 3'd3,
      ACT_SEARCH  = 3'd4,
      ACT_COMPARE = 3'd5,
      ACT_SWAP    = 3'd6,
      ACT_CLEAR   = 3'd7
   } action_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STS_OK    = 2'd0,
      STS_RANGE = 2'd1,
      STS_FULL  = 2'd2,
      STS_EMPTY = 2'd3
   } status_type;

   // Per-cycle operation broadcast to every cell of the chain
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_WRITE,
      CELL_SWAP
   } cell_op_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_EXEC,
      FSM_SWAP,
      FSM_DONE
   } fsm_state_type;

   typedef struct packed {
      action_type                    action;
      logic [INDEX_BITS-1:0]         index;
      logic [SECOND_INDEX_BITS-1:0]  second_index;
      logic signed [DATA_BITS-1:0]   value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_BITS-1:0]   read_data;
      logic                          match;
      status_type                    status;
      logic [COUNT_BITS-1:0]         count;
      logic                          is_empty;
   } rsp_type;

endpackage

[rtl/core/ilst_chan_if.sv]
interface ilst_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/ilst_cell.sv]
module ilst_cell #(
   parameter int POS        = 0,
   parameter int CMP_W      = 7,
   parameter int VALUE_BITS = 32
) (
   input  logic                    clock,
   input  ilst_pkg::cell_op_type   op,
   input  logic [CMP_W-1:0]        pos_a,
   input  logic [CMP_W-1:0]        pos_b,
   input  logic [CMP_W-1:0]        limit,
   input  logic [VALUE_BITS-1:0]   data_a,
   input  logic [VALUE_BITS-1:0]   data_b,
   input  logic [VALUE_BITS-1:0]   left_value,
   input  logic [VALUE_BITS-1:0]   right_value,
   output logic [VALUE_BITS-1:0]   value,
   output logic [VALUE_BITS-1:0]   tap_a,
   output logic [VALUE_BITS-1:0]   tap_b,
   output logic                    key_hit
);
   import ilst_pkg::*;

   localparam logic [CMP_W-1:0] SELF = CMP_W'(POS);

   logic [VALUE_BITS-1:0] value_ff;
   logic [VALUE_BITS-1:0] value_in;
   logic                  at_a;
   logic                  at_b;

   assign at_a  = (pos_a == SELF);
   assign at_b  = (pos_b == SELF);
   assign value = value_ff;

   // Pick the next content from self, a neighbor or the broadcast data
   always_comb begin
      value_in = value_ff;
      unique case (op)
         CELL_HOLD: begin
            value_in = value_ff;
         end
         CELL_INSERT: begin
            if (at_a) begin
               value_in = data_a;
            end else if (SELF > pos_a) begin
               value_in = left_value;
            end
         end
         CELL_REMOVE: begin
            if (SELF >= pos_a) begin
               value_in = right_value;
            end
         end
         CELL_WRITE: begin
            if (at_a) begin
               value_in = data_a;
            end
         end
         CELL_SWAP: begin
            if (at_a) begin
               value_in = data_a;
            end else if (at_b) begin
               value_in = data_b;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   // Drive taps onto the wired-or read buses
   assign tap_a   = at_a ? value_ff : '0;
   assign tap_b   = at_b ? value_ff : '0;
   assign key_hit = (SELF < limit) && (value_ff == data_a);

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

[rtl/core/indexed_list_store_core.sv]
// Channel   Dir  Beat payload                                   Handshake
// req_chan  in   action, index, second_index, value              valid / ready
// rsp_chan  out  read_data, match, status, count, is_empty       valid / ready
//
// One command is in flight at a time: each command passes through idle,
// execute and done, and the result register loads in done once rsp_chan can
// take it. A swap of two distinct positions adds a swap state: execute reads
// both positions off the cell chain, the swap state writes them back.
// The chain of CAPACITY cells shifts, writes and compares all positions at once.
// Synchronous reset empties the list; cell contents are not cleared.
// A stalled rsp_chan holds the finished result and keeps req_chan not ready.
module indexed_list_store_core #(
   parameter int CAPACITY   = ilst_pkg::CAPACITY_DEF,
   parameter int VALUE_BITS = ilst_pkg::VALUE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   ilst_chan_if.sink   req_chan,
   ilst_chan_if.source rsp_chan
);
   import ilst_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > INDEX_BITS) ? CNT_W : INDEX_BITS;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

   fsm_state_type state_ff;
   fsm_state_type state_in;

   req_type               cmd_ff;
   rsp_type               res_ff;
   rsp_type               res_in;
   rsp_type               rsp_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic [VALUE_BITS-1:0] swap_a_ff;
   logic [VALUE_BITS-1:0] swap_b_ff;

   logic                  accept;
   logic                  load_rsp;
   logic                  exec_swap;
   cell_op_type           cell_op;
   logic [CMP_W-1:0]      pos_a;
   logic [CMP_W-1:0]      pos_b;
   logic [CMP_W-1:0]      limit;
   logic [CMP_W-1:0]      count_w;
   logic [VALUE_BITS-1:0] key_val;
   logic [VALUE_BITS-1:0] data_a;
   logic [VALUE_BITS-1:0] data_b;
   logic [VALUE_BITS-1:0] tap_a_or;
   logic [VALUE_BITS-1:0] tap_b_or;
   logic                  hit_or;

   logic [VALUE_BITS-1:0] cell_value [CAPACITY];
   logic [VALUE_BITS-1:0] tap_a_arr  [CAPACITY];
   logic [VALUE_BITS-1:0] tap_b_arr  [CAPACITY];
   logic                  hit_arr    [CAPACITY];

   assign accept  = req_chan.valid && req_chan.ready;
   assign pos_a   = CMP_W'(cmd_ff.index);
   assign pos_b   = CMP_W'(cmd_ff.second_index);
   assign count_w = CMP_W'(count_ff);
   assign limit   = count_w;
   assign key_val = VALUE_BITS'($unsigned(cmd_ff.value));

   // Build the chain; the end cells see themselves past the edge
   for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [VALUE_BITS-1:0] left_value;
      logic [VALUE_BITS-1:0] right_value;

      if (gi == 0) begin : g_head
         assign left_value = cell_value[gi];
      end else begin : g_body_l
         assign left_value = cell_value[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_tail
         assign right_value = cell_value[gi];
      end else begin : g_body_r
         assign right_value = cell_value[gi+1];
      end

      ilst_cell #(
         .POS        (gi),
         .CMP_W      (CMP_W),
         .VALUE_BITS (VALUE_BITS)
      ) u_cell (
         .clock       (clock),
         .op          (cell_op),
         .pos_a       (pos_a),
         .pos_b       (pos_b),
         .limit       (limit),
         .data_a      (data_a),
         .data_b      (data_b),
         .left_value  (left_value),
         .right_value (right_value),
         .value       (cell_value[gi]),
         .tap_a       (tap_a_arr[gi]),
         .tap_b       (tap_b_arr[gi]),
         .key_hit     (hit_arr[gi])
      );
   end

   // Merge the cell taps and search hits
   always_comb begin
      tap_a_or = '0;
      tap_b_or = '0;
      hit_or   = 1'b0;
      for (int i = 0; i < CAPACITY; i++) begin
         tap_a_or = tap_a_or | tap_a_arr[i];
         tap_b_or = tap_b_or | tap_b_arr[i];
         hit_or   = hit_or | hit_arr[i];
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               state_in = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            state_in = exec_swap ? FSM_SWAP : FSM_DONE;
         end
         FSM_SWAP: begin
            state_in = FSM_DONE;
         end
         FSM_DONE: begin
            if (load_rsp) begin
               state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   // Decode the held command and drive the chain
   always_comb begin
      req_chan.ready = 1'b0;
      cell_op        = CELL_HOLD;
      data_a         = key_val;
      data_b         = swap_a_ff;
      count_in       = count_ff;
      res_in         = res_ff;
      exec_swap      = 1'b0;
      load_rsp       = 1'b0;
      unique case (state_ff)
         FSM_IDLE: begin
            req_chan.ready = 1'b1;
         end
         FSM_EXEC: begin
            res_in.read_data = '0;
            res_in.match     = 1'b0;
            res_in.status    = STS_OK;
            priority if (cmd_ff.action == ACT_INSERT) begin
               if (CMP_W'(cmd_ff.index) > count_w) begin
                  res_in.status = STS_RANGE;
               end else if (count_ff == FULL_COUNT) begin
                  res_in.status = STS_FULL;
               end else begin
                  cell_op  = CELL_INSERT;
                  count_in = count_ff + 1'b1;
               end
            end else if (cmd_ff.action == ACT_CLEAR) begin
               count_in = '0;
            end else if (count_ff == '0) begin
               res_in.status = STS_EMPTY;
            end else if (cmd_ff.action == ACT_SEARCH) begin
               res_in.match = hit_or;
            end else if (cmd_ff.action == ACT_SWAP) begin
               if (pos_a >= count_w || pos_b >= count_w) begin
                  res_in.status = STS_RANGE;
               end else if (pos_a != pos_b) begin
                  exec_swap = 1'b1;
               end
            end else if (pos_a >= count_w) begin
               res_in.status = STS_RANGE;
            end else begin
               unique case (cmd_ff.action)
                  ACT_REMOVE: begin
                     cell_op  = CELL_REMOVE;
                     count_in = count_ff - 1'b1;
                  end
                  ACT_REPLACE: begin
                     cell_op = CELL_WRITE;
                  end
                  ACT_READ: begin
                     res_in.read_data = DATA_BITS'(signed'(tap_a_or));
                  end
                  default: begin
                     res_in.match = (tap_a_or == key_val);
                  end
               endcase
            end
         end
         FSM_SWAP: begin
            cell_op = CELL_SWAP;
            data_a  = swap_b_ff;
            data_b  = swap_a_ff;
         end
         FSM_DONE: begin
            load_rsp = !rsp_valid_ff || rsp_chan.ready;
         end
         default: begin
            req_chan.ready = 1'b0;
         end
      endcase
   end

   // Hold the result until the sink takes the beat
   assign rsp_valid_in     = load_rsp ? 1'b1 : (rsp_valid_ff && !rsp_chan.ready);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_chan.payload;
      end
      if (state_ff == FSM_EXEC) begin
         swap_a_ff <= tap_a_or;
         swap_b_ff <= tap_b_or;
      end
      res_ff <= res_in;
      if (load_rsp) begin
         rsp_ff <= '{read_data: res_ff.read_data,
                     match:     res_ff.match,
                     status:    res_ff.status,
                     count:     COUNT_BITS'(count_ff),
                     is_empty:  (count_ff == '0)};
      end
   end

endmodule
